### src/tdts_pkg.sv
// tdts_pkg: shared types and constants for the table driven token scanner
// token codes, error codes, keyword tables and the queue record
// no dependencies
package tdts_pkg;

    localparam int WORD_LEN_W       = 5;
    localparam int DEF_MAX_WORD_LEN = 20;
    localparam int DEF_QUEUE_DEPTH  = 4;
    localparam int LINE_W           = 16;
    localparam int KIND_W           = 4;
    localparam int ERR_W            = 3;
    localparam int NUM_KW           = 4;

    typedef enum logic [KIND_W-1:0] {
        TK_INICIO   = 4'd0,
        TK_FIN      = 4'd1,
        TK_LEER     = 4'd2,
        TK_ESCRIBIR = 4'd3,
        TK_ID       = 4'd4,
        TK_CONST    = 4'd5,
        TK_LPAREN   = 4'd6,
        TK_RPAREN   = 4'd7,
        TK_SEMI     = 4'd8,
        TK_COMMA    = 4'd9,
        TK_ASSIGN   = 4'd10,
        TK_PLUS     = 4'd11,
        TK_MINUS    = 4'd12,
        TK_EOF      = 4'd13,
        TK_ERROR    = 4'd14
    } token_kind_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE        = 3'd0,
        ERR_DIGIT_ALPHA = 3'd1,
        ERR_LONE_EQUAL  = 3'd2,
        ERR_BAD_COLON   = 3'd3,
        ERR_UNKNOWN     = 3'd4
    } error_kind_t;

    // keyword spelling, one row per keyword, padded with nul
    localparam logic [7:0] KW_CHARS [NUM_KW][8] = '{
        '{"i", "n", "i", "c", "i", "o", 8'h00, 8'h00},
        '{"f", "i", "n", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"l", "e", "e", "r", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"e", "s", "c", "r", "i", "b", "i", "r"}
    };
    localparam logic [WORD_LEN_W-1:0] KW_LEN [NUM_KW] = '{5'd6, 5'd3, 5'd4, 5'd8};

    // one queue entry: the tokens one input word produced
    typedef struct packed {
        logic                two;
        token_kind_t         kind0;
        error_kind_t         err0;
        token_kind_t         kind1;
        error_kind_t         err1;
        logic [LINE_W-1:0]   line;
    } tok_rec_t;

endpackage

### src/tdts_front.sv
// tdts_front: byte classifier and scanner automaton
// produces one queue record per input word that yields tokens
// depends on tdts_pkg
module tdts_front import tdts_pkg::*; #(
    parameter int MAX_WORD_LEN = DEF_MAX_WORD_LEN
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic [7:0]        char_code,
    input  logic              end_of_input,
    output logic              push,
    output tok_rec_t          push_data
);

    typedef enum logic [1:0] {
        ST_START, ST_IDENT, ST_CONST, ST_COLON
    } scan_state_t;

    typedef enum logic [3:0] {
        CL_LETTER, CL_DIGIT, CL_SPACE, CL_END, CL_OTHER, CL_PLUS, CL_MINUS,
        CL_LPAREN, CL_RPAREN, CL_COMMA, CL_SEMI, CL_COLON, CL_EQUAL
    } char_class_t;

    typedef struct packed {
        logic        has;
        token_kind_t kind;
        error_kind_t err;
        scan_state_t state;
        logic        skip;
    } step_t;

    scan_state_t             state_reg, state_next;
    logic                    skip_reg, skip_next;
    logic [LINE_W-1:0]       line_reg, line_next;
    logic [WORD_LEN_W-1:0]   len_reg, len_next;
    logic [NUM_KW-1:0]       kw_reg, kw_next;

    char_class_t  cl;
    scan_state_t  st_eff;
    step_t        s1, s2;
    logic         again;
    logic         fire;

    function automatic char_class_t classify(input logic [7:0] c);
        char_class_t r;
        if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z")) r = CL_LETTER;
        else if (c >= "0" && c <= "9") r = CL_DIGIT;
        else if (c == " " || (c >= 8'd9 && c <= 8'd13)) r = CL_SPACE;
        else begin
            unique case (c)
                "+":     r = CL_PLUS;
                "-":     r = CL_MINUS;
                "(":     r = CL_LPAREN;
                ")":     r = CL_RPAREN;
                ",":     r = CL_COMMA;
                ";":     r = CL_SEMI;
                ":":     r = CL_COLON;
                "=":     r = CL_EQUAL;
                default: r = CL_OTHER;
            endcase
        end
        return r;
    endfunction

    // drop each keyword whose letter at position p differs
    function automatic logic [NUM_KW-1:0] add_kw(input logic [WORD_LEN_W-1:0] p,
                                                 input logic [7:0] c,
                                                 input logic [NUM_KW-1:0] kw);
        logic [NUM_KW-1:0] r;
        r = kw;
        for (int k = 0; k < NUM_KW; k++) begin
            if (!(p < KW_LEN[k] && KW_CHARS[k][p[2:0]] == c)) r[k] = 1'b0;
        end
        return r;
    endfunction

    function automatic token_kind_t word_token(input logic [WORD_LEN_W-1:0] len,
                                               input logic [NUM_KW-1:0] kw);
        token_kind_t r;
        r = TK_ID;
        for (int k = NUM_KW - 1; k >= 0; k--) begin
            if (kw[k] && len == KW_LEN[k]) r = token_kind_t'(k[KIND_W-1:0]);
        end
        return r;
    endfunction

    function automatic step_t mk(input logic has, input token_kind_t kind,
                                 input error_kind_t err, input scan_state_t st,
                                 input logic skip);
        step_t r;
        r.has = has; r.kind = kind; r.err = err; r.state = st; r.skip = skip;
        return r;
    endfunction

    // one pass from the start state
    function automatic step_t start_step(input char_class_t c);
        step_t r;
        unique case (c)
            CL_LETTER: r = mk(1'b0, TK_ID, ERR_NONE, ST_IDENT, 1'b0);
            CL_DIGIT:  r = mk(1'b0, TK_CONST, ERR_NONE, ST_CONST, 1'b0);
            CL_SPACE:  r = mk(1'b0, TK_ID, ERR_NONE, ST_START, 1'b0);
            CL_END:    r = mk(1'b1, TK_EOF, ERR_NONE, ST_START, 1'b0);
            CL_PLUS:   r = mk(1'b1, TK_PLUS, ERR_NONE, ST_START, 1'b0);
            CL_MINUS:  r = mk(1'b1, TK_MINUS, ERR_NONE, ST_START, 1'b0);
            CL_LPAREN: r = mk(1'b1, TK_LPAREN, ERR_NONE, ST_START, 1'b0);
            CL_RPAREN: r = mk(1'b1, TK_RPAREN, ERR_NONE, ST_START, 1'b0);
            CL_COMMA:  r = mk(1'b1, TK_COMMA, ERR_NONE, ST_START, 1'b0);
            CL_SEMI:   r = mk(1'b1, TK_SEMI, ERR_NONE, ST_START, 1'b0);
            CL_COLON:  r = mk(1'b0, TK_ID, ERR_NONE, ST_COLON, 1'b0);
            CL_EQUAL:  r = mk(1'b1, TK_ERROR, ERR_LONE_EQUAL, ST_START, 1'b1);
            default:   r = mk(1'b1, TK_ERROR, ERR_UNKNOWN, ST_START, 1'b1);
        endcase
        return r;
    endfunction

    assign fire = in_valid && in_ready;

    always_comb begin
        cl = (end_of_input || char_code == 8'd0) ? CL_END : classify(char_code);
        line_next = line_reg;
        if (cl != CL_END && char_code == 8'd10 && line_reg != {LINE_W{1'b1}})
            line_next = line_reg + 1'b1;

        st_eff     = skip_reg ? ST_START : state_reg;
        state_next = state_reg;
        skip_next  = skip_reg;
        len_next   = len_reg;
        kw_next    = kw_reg;
        again      = 1'b0;
        s1         = mk(1'b0, TK_ID, ERR_NONE, state_reg, skip_reg);
        s2         = start_step(cl);

        if (!(skip_reg && (cl == CL_LETTER || cl == CL_DIGIT))) begin
            unique case (st_eff)
                ST_IDENT: begin
                    if (cl == CL_LETTER || cl == CL_DIGIT)
                        s1 = mk(1'b0, TK_ID, ERR_NONE, ST_IDENT, 1'b0);
                    else if (cl == CL_OTHER)
                        s1 = mk(1'b1, TK_ERROR, ERR_UNKNOWN, ST_START, 1'b1);
                    else begin
                        s1 = mk(1'b1, word_token(len_reg, kw_reg), ERR_NONE,
                                ST_START, 1'b0);
                        again = 1'b1;
                    end
                end
                ST_CONST: begin
                    if (cl == CL_DIGIT)
                        s1 = mk(1'b0, TK_CONST, ERR_NONE, ST_CONST, 1'b0);
                    else if (cl == CL_LETTER)
                        s1 = mk(1'b1, TK_ERROR, ERR_DIGIT_ALPHA, ST_START, 1'b1);
                    else if (cl == CL_OTHER)
                        s1 = mk(1'b1, TK_ERROR, ERR_UNKNOWN, ST_START, 1'b1);
                    else begin
                        s1 = mk(1'b1, TK_CONST, ERR_NONE, ST_START, 1'b0);
                        again = 1'b1;
                    end
                end
                ST_COLON: begin
                    if (cl == CL_EQUAL)
                        s1 = mk(1'b1, TK_ASSIGN, ERR_NONE, ST_START, 1'b0);
                    else if (cl == CL_OTHER)
                        s1 = mk(1'b1, TK_ERROR, ERR_UNKNOWN, ST_START, 1'b1);
                    else begin
                        s1 = mk(1'b1, TK_ERROR, ERR_BAD_COLON, ST_START, 1'b1);
                        again = (cl == CL_END);
                    end
                end
                default: s1 = s2;
            endcase

            // identifier bookkeeping
            if (st_eff == ST_IDENT && (cl == CL_LETTER || cl == CL_DIGIT)) begin
                kw_next  = add_kw(len_reg, char_code, kw_reg);
                len_next = (len_reg < WORD_LEN_W'(MAX_WORD_LEN)) ? len_reg + 1'b1 : len_reg;
            end else if (st_eff == ST_START && cl == CL_LETTER) begin
                kw_next  = add_kw('0, char_code, {NUM_KW{1'b1}});
                len_next = WORD_LEN_W'(1);
            end

            state_next = s1.state;
            skip_next  = s1.skip;
            // re-read of the terminating byte from the start state
            if (again) begin
                state_next = s2.state;
                skip_next  = s1.skip | s2.skip;
            end
        end

        push_data.two   = again && s2.has;
        push_data.kind0 = s1.kind;
        push_data.err0  = s1.err;
        push_data.kind1 = s2.kind;
        push_data.err1  = s2.err;
        push_data.line  = line_next;
        push = fire && s1.has;
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            state_reg <= ST_START;
            skip_reg  <= 1'b0;
            line_reg  <= LINE_W'(1);
            len_reg   <= '0;
            kw_reg    <= {NUM_KW{1'b1}};
        end else if (fire) begin
            state_reg <= state_next;
            skip_reg  <= skip_next;
            line_reg  <= line_next;
            len_reg   <= len_next;
            kw_reg    <= kw_next;
        end
    end

endmodule

### src/tdts_queue.sv
// tdts_queue: short record queue between scanner front and token back end
// register array with read and write pointers
// depends on tdts_pkg
module tdts_queue import tdts_pkg::*; #(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  tok_rec_t  push_data,
    input  logic      pop,
    output tok_rec_t  pop_data,
    output logic      empty,
    output logic      full
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    tok_rec_t              mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;

    function automatic logic [PTR_W-1:0] inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign empty    = (cnt_reg == '0);
    assign full     = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign pop_data = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = (push && !full) ? inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = (pop && !empty) ? inc(rd_ptr_reg) : rd_ptr_reg;
        cnt_next    = cnt_reg + CNT_W'(push && !full) - CNT_W'(pop && !empty);
    end

    always_ff @(posedge clk) begin
        if (push && !full) mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

### src/tdts_back.sv
// tdts_back: splits queue records into single tokens on the output register
// holds the second token of a two-token record until the first is taken
// depends on tdts_pkg
module tdts_back import tdts_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  tok_rec_t           q_data,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_ready,
    output token_kind_t        out_kind,
    output error_kind_t        out_err,
    output logic [LINE_W-1:0]  out_line,
    output logic               out_last
);

    logic               valid_reg;
    token_kind_t        kind_reg;
    error_kind_t        err_reg;
    logic [LINE_W-1:0]  line_reg;
    logic               last_reg;
    logic               pend_reg;
    token_kind_t        pend_kind_reg;
    error_kind_t        pend_err_reg;
    logic               out_free;

    assign out_free  = !valid_reg || out_ready;
    assign q_pop     = out_free && !pend_reg && !q_empty;
    assign out_valid = valid_reg;
    assign out_kind  = kind_reg;
    assign out_err   = err_reg;
    assign out_line  = line_reg;
    assign out_last  = last_reg;

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end else if (out_free) begin
            if (pend_reg) begin
                valid_reg <= 1'b1;
                kind_reg  <= pend_kind_reg;
                err_reg   <= pend_err_reg;
                last_reg  <= 1'b1;
                pend_reg  <= 1'b0;
            end else if (!q_empty) begin
                valid_reg     <= 1'b1;
                kind_reg      <= q_data.kind0;
                err_reg       <= q_data.err0;
                line_reg      <= q_data.line;
                last_reg      <= !q_data.two;
                pend_reg      <= q_data.two;
                pend_kind_reg <= q_data.kind1;
                pend_err_reg  <= q_data.err1;
            end else begin
                valid_reg <= 1'b0;
            end
        end
    end

endmodule

### src/table_driven_token_scanner.sv
// table_driven_token_scanner: top level of the byte stream token scanner
// ties the scanner front, the record queue and the token back end together
// depends on tdts_pkg, tdts_front, tdts_queue, tdts_back
//
// the scanner takes one byte per word on the s_ side and gives tokens of the
// small language (keywords inicio fin leer escribir, identifiers, decimal
// constants, + - ( ) , ; :=, eof and error) on the m_ side. a byte or an
// end mark is taken every cycle while the record queue has room; the front
// automaton steps once per cycle, so bytes enter at one per cycle. a byte
// that yields no token costs nothing downstream, and a byte that closes a
// word and is itself a token yields two tokens at the output; the output
// register emits one token per cycle while m_tready is high, which sets the
// sustained rate when tokens come denser than bytes. the first token of
// an accepted byte goes into the record queue, then the output register.
// m_tlast marks the last token caused by one input word, and all tokens
// carry the line count including that word's newline.
module table_driven_token_scanner import tdts_pkg::*; #(
    parameter int MAX_WORD_LEN = DEF_MAX_WORD_LEN,
    parameter int QUEUE_DEPTH  = DEF_QUEUE_DEPTH
) (
    input  logic         aclk,
    input  logic         aresetn,
    // input words
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] char_code
    input  logic         s_tuser,   // [0] end_of_input
    // token words
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [23:0]  m_tdata,   // [3:0] token_kind, [6:4] error_kind,
                                    // [22:7] line_number, [23] zero
    output logic         m_tlast    // last_of_run
);

    logic               q_push, q_pop, q_empty, q_full;
    tok_rec_t           q_wdata, q_rdata;
    token_kind_t        out_kind;
    error_kind_t        out_err;
    logic [LINE_W-1:0]  out_line;

    // the front may step only when a record can be stored
    assign s_tready = !q_full;

    tdts_front #(
        .MAX_WORD_LEN(MAX_WORD_LEN)
    ) u_front (
        .clk          (aclk),
        .rst_n        (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .char_code    (s_tdata),
        .end_of_input (s_tuser),
        .push         (q_push),
        .push_data    (q_wdata)
    );

    tdts_queue #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk       (aclk),
        .rst_n     (aresetn),
        .push      (q_push),
        .push_data (q_wdata),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .empty     (q_empty),
        .full      (q_full)
    );

    tdts_back u_back (
        .clk       (aclk),
        .rst_n     (aresetn),
        .q_empty   (q_empty),
        .q_data    (q_rdata),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_kind  (out_kind),
        .out_err   (out_err),
        .out_line  (out_line),
        .out_last  (m_tlast)
    );

    // pack token fields, lowest field first, padded to whole bytes
    assign m_tdata = {1'b0, out_line, out_err, out_kind};

endmodule

### sim/table_driven_token_scanner_test.sv
// table_driven_token_scanner_test: self-checking bench for the byte stream token scanner
// drives bytes and end marks, predicts every token word and checks it field by field
// depends on tdts_pkg and table_driven_token_scanner
`timescale 1ns / 1ps

module table_driven_token_scanner_test;
    import tdts_pkg::*;

    localparam int MAX_WORD       = DEF_MAX_WORD_LEN;
    localparam int HOLDOFF_CYCLES = 80;     // long receiver stall, fills the record queue
    localparam int WATCHDOG_LIMIT = 2000;   // cycles with no word moving on either side
    localparam int DRAIN_CYCLES   = 16;     // settle time after the last token
    localparam int PHASE_ITEMS    = 590;
    localparam int REPORT_LIMIT   = 10;

    localparam logic [LINE_W-1:0] LINE_TOP = '1;

    // byte codes the scanner treats specially
    localparam logic [7:0] NUL = 8'h00;
    localparam logic [7:0] TAB = 8'h09;
    localparam logic [7:0] LF  = 8'h0A;
    localparam logic [7:0] VT  = 8'h0B;
    localparam logic [7:0] FF  = 8'h0C;
    localparam logic [7:0] CR  = 8'h0D;

    typedef enum logic [1:0] {
        SCAN_START,
        SCAN_IDENT,
        SCAN_CONST,
        SCAN_COLON
    } scan_state_t;

    typedef enum logic [3:0] {
        CC_LETTER, CC_DIGIT, CC_SPACE, CC_END, CC_OTHER, CC_PLUS, CC_MINUS,
        CC_LPAREN, CC_RPAREN, CC_COMMA, CC_SEMI, CC_COLON, CC_EQUAL
    } char_class_t;

    typedef struct {
        logic [7:0] ch;
        logic       eoi;
    } scan_item_t;

    typedef struct {
        token_kind_t       kind;
        error_kind_t       err;
        logic [LINE_W-1:0] line;
        logic              last;
    } token_word_t;

    logic         aclk;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata  = 8'h00;
    logic         s_tuser  = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [23:0]  m_tdata;
    logic         m_tlast;

    table_driven_token_scanner dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // [7:0] char_code
        .s_tuser  (s_tuser),    // [0] end_of_input
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // [3:0] token_kind, [6:4] error_kind, [22:7] line_number
        .m_tlast  (m_tlast)     // last_of_run
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // stimulus and expectation stores
    scan_item_t  pending_bytes[$];
    token_word_t token_fifo[$];
    token_word_t fresh[$];          // tokens of the byte being predicted

    int queued_items  = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int stall_req     = 0;
    int stall_done    = 0;
    int hold_left     = 0;
    int fault_count   = 0;
    int tokens_seen   = 0;
    int idle_cycles   = 0;
    logic in_taken    = 1'b0;

    // scanner shadow state
    scan_state_t       tb_scan   = SCAN_START;
    logic              tb_skip   = 1'b0;
    logic [LINE_W-1:0] tb_line   = LINE_W'(1);
    logic [4:0]        tb_wlen   = '0;
    logic [NUM_KW-1:0] tb_kwmask = '1;

    function automatic void note_fault(string what);
        fault_count++;
        if (fault_count <= REPORT_LIMIT) $display("mismatch: %s", what);
    endfunction

    // ---------------------------------------------------------------
    // token predictor
    // ---------------------------------------------------------------

    function automatic char_class_t class_of(logic [7:0] c);
        if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z")) return CC_LETTER;
        if (c >= "0" && c <= "9") return CC_DIGIT;
        if (c == " " || (c >= TAB && c <= CR)) return CC_SPACE;
        case (c)
            "+": return CC_PLUS;
            "-": return CC_MINUS;
            "(": return CC_LPAREN;
            ")": return CC_RPAREN;
            ",": return CC_COMMA;
            ";": return CC_SEMI;
            ":": return CC_COLON;
            "=": return CC_EQUAL;
            default: return CC_OTHER;
        endcase
    endfunction

    // at most two tokens per byte, extra ones are dropped
    task automatic emit_token(token_kind_t k, error_kind_t e);
        token_word_t t;
        if (fresh.size() < 2) begin
            t.kind = k;
            t.err  = e;
            t.line = tb_line;
            t.last = 1'b0;
            fresh.push_back(t);
        end
    endtask

    task automatic raise_error(error_kind_t e);
        tb_scan = SCAN_START;
        tb_skip = 1'b1;
        emit_token(TK_ERROR, e);
    endtask

    // knock out keywords that no longer match at this position
    task automatic extend_word(logic [7:0] ch);
        int k;
        for (k = 0; k < NUM_KW; k++) begin
            if (!(tb_wlen < KW_LEN[k] && KW_CHARS[k][tb_wlen[2:0]] == ch))
                tb_kwmask[k] = 1'b0;
        end
        if (tb_wlen < MAX_WORD) tb_wlen++;
    endtask

    function automatic token_kind_t word_kind();
        int k;
        for (k = 0; k < NUM_KW; k++) begin
            if (tb_kwmask[k] && tb_wlen == KW_LEN[k]) return token_kind_t'(k);
        end
        return TK_ID;
    endfunction

    // one automaton step; again is set when the byte must be re-read from start
    task automatic scan_pass(char_class_t cl, logic [7:0] ch, output bit again);
        again = 1'b0;
        case (tb_scan)
            SCAN_IDENT: begin
                if (cl == CC_LETTER || cl == CC_DIGIT) begin
                    extend_word(ch);
                end else if (cl == CC_OTHER) begin
                    raise_error(ERR_UNKNOWN);
                end else begin
                    tb_scan = SCAN_START;
                    again   = 1'b1;
                    emit_token(word_kind(), ERR_NONE);
                end
            end
            SCAN_CONST: begin
                if (cl == CC_DIGIT) begin
                end else if (cl == CC_LETTER) begin
                    raise_error(ERR_DIGIT_ALPHA);
                end else if (cl == CC_OTHER) begin
                    raise_error(ERR_UNKNOWN);
                end else begin
                    tb_scan = SCAN_START;
                    again   = 1'b1;
                    emit_token(TK_CONST, ERR_NONE);
                end
            end
            SCAN_COLON: begin
                if (cl == CC_EQUAL) begin
                    tb_scan = SCAN_START;
                    emit_token(TK_ASSIGN, ERR_NONE);
                end else if (cl == CC_OTHER) begin
                    raise_error(ERR_UNKNOWN);
                end else begin
                    // end after a colon still yields eof on the second pass
                    again = (cl == CC_END);
                    raise_error(ERR_BAD_COLON);
                end
            end
            default: begin
                tb_scan = SCAN_START;
                case (cl)
                    CC_LETTER: begin
                        tb_scan   = SCAN_IDENT;
                        tb_wlen   = '0;
                        tb_kwmask = '1;
                        extend_word(ch);
                    end
                    CC_DIGIT:  tb_scan = SCAN_CONST;
                    CC_SPACE:  begin end
                    CC_END:    emit_token(TK_EOF, ERR_NONE);
                    CC_PLUS:   emit_token(TK_PLUS, ERR_NONE);
                    CC_MINUS:  emit_token(TK_MINUS, ERR_NONE);
                    CC_LPAREN: emit_token(TK_LPAREN, ERR_NONE);
                    CC_RPAREN: emit_token(TK_RPAREN, ERR_NONE);
                    CC_COMMA:  emit_token(TK_COMMA, ERR_NONE);
                    CC_SEMI:   emit_token(TK_SEMI, ERR_NONE);
                    CC_COLON:  tb_scan = SCAN_COLON;
                    CC_EQUAL:  raise_error(ERR_LONE_EQUAL);
                    default:   raise_error(ERR_UNKNOWN);
                endcase
            end
        endcase
    endtask

    task automatic scan_byte(logic [7:0] ch, logic eoi);
        char_class_t cl;
        bit          again;
        int          p;
        fresh.delete();
        // nul behaves as an end mark
        cl = (eoi || ch == NUL) ? CC_END : class_of(ch);
        // a newline counts once, even if it is re-read after closing a word
        if (cl != CC_END && ch == LF && tb_line != LINE_TOP) tb_line++;
        if (tb_skip) begin
            // letters and digits after an error are swallowed
            if (cl == CC_LETTER || cl == CC_DIGIT) return;
            tb_skip = 1'b0;
            tb_scan = SCAN_START;
        end
        for (p = 0; p < 2; p++) begin
            scan_pass(cl, ch, again);
            if (!again) break;
        end
        if (fresh.size() > 0) fresh[fresh.size() - 1].last = 1'b1;
        foreach (fresh[i]) token_fifo.push_back(fresh[i]);
    endtask

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------

    task automatic push_byte(logic [7:0] ch);
        scan_item_t it;
        it.ch  = ch;
        it.eoi = 1'b0;
        pending_bytes.push_back(it);
        queued_items++;
    endtask

    // end mark carries a random byte that must be ignored
    task automatic push_end();
        scan_item_t it;
        it.ch  = 8'($urandom_range(255));
        it.eoi = 1'b1;
        pending_bytes.push_back(it);
        queued_items++;
    endtask

    task automatic push_text(string s);
        int i;
        for (i = 0; i < s.len(); i++) push_byte(s[i]);
    endtask

    function automatic logic [7:0] random_letter();
        logic [7:0] base;
        base = $urandom_range(1) ? "a" : "A";
        return 8'(base + $urandom_range(25));
    endfunction

    function automatic logic [7:0] random_digit();
        logic [7:0] base;
        base = "0";
        return 8'(base + $urandom_range(9));
    endfunction

    function automatic logic [7:0] random_space();
        case ($urandom_range(6))
            0:       return " ";
            1:       return TAB;
            2:       return CR;
            3:       return VT;
            4:       return FF;
            default: return LF;
        endcase
    endfunction

    task automatic push_operator();
        case ($urandom_range(8))
            0: push_byte("+");
            1: push_byte("-");
            2: push_byte("(");
            3: push_byte(")");
            4: push_byte(",");
            5: push_byte(";");
            6: push_byte("=");
            default: push_text(":=");
        endcase
    endtask

    task automatic push_keyword(int k, int len);
        int i;
        for (i = 0; i < len; i++) push_byte(KW_CHARS[k][i]);
    endtask

    // mostly well-formed lexemes with random content, some noise and broken input
    task automatic add_random(int n);
        int target;
        int pick;
        int k;
        int len;
        target = queued_items + n;
        while (queued_items < target) begin
            pick = $urandom_range(99);
            if (pick < 15) begin
                push_keyword($urandom_range(NUM_KW - 1), 0);
                k = $urandom_range(NUM_KW - 1);
                push_keyword(k, KW_LEN[k]);
            end else if (pick < 20) begin
                // keyword prefix, possibly with a tail
                k = $urandom_range(NUM_KW - 1);
                push_keyword(k, $urandom_range(1, KW_LEN[k] - 1));
                if ($urandom_range(1)) push_byte(random_letter());
            end else if (pick < 35) begin
                push_byte(random_letter());
                len = ($urandom_range(14) == 0) ? $urandom_range(18, 27) : $urandom_range(5);
                repeat (len) push_byte($urandom_range(2) == 0 ? random_digit() : random_letter());
            end else if (pick < 46) begin
                repeat ($urandom_range(1, 5)) push_byte(random_digit());
            end else if (pick < 66) begin
                push_operator();
            end else if (pick < 80) begin
                push_byte(random_space());
            end else if (pick < 85) begin
                if ($urandom_range(1)) push_end();
                else push_byte(NUL);
            end else if (pick < 90) begin
                push_byte(":");
                push_byte(8'($urandom_range(255)));
            end else if (pick < 94) begin
                repeat ($urandom_range(1, 3)) push_byte(random_digit());
                push_byte(random_letter());
            end else begin
                push_byte(8'($urandom_range(255)));
            end
            // words usually get a separator so keywords are closed cleanly
            if (pick < 46 && $urandom_range(9) < 7) begin
                if ($urandom_range(1)) push_byte(random_space());
                else push_operator();
            end
        end
    endtask

    function automatic bit drained();
        return pending_bytes.size() == 0 && !s_tvalid && token_fifo.size() == 0;
    endfunction

    task automatic wait_drained();
        while (!drained()) @(posedge aclk);
    endtask

    // ---------------------------------------------------------------
    // byte driver: new word at the falling edge, held until taken
    // ---------------------------------------------------------------
    always @(negedge aclk) begin
        scan_item_t it;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_taken) begin
            if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                it = pending_bytes.pop_front();
                s_tdata  <= it.ch;
                s_tuser  <= it.eoi;
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // token receiver: random back-pressure plus one long requested stall
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (stall_done != stall_req) begin
            m_tready   <= 1'b0;
            hold_left  <= HOLDOFF_CYCLES - 1;
            stall_done <= stall_done + 1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ---------------------------------------------------------------
    // monitor: check token words, predict from accepted bytes
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        token_word_t want;
        in_taken <= s_tvalid && s_tready;
        if (aresetn && m_tvalid && m_tready) begin
            if (token_fifo.size() == 0) begin
                note_fault($sformatf("token %0d not expected: data %h last %b",
                                     tokens_seen, m_tdata, m_tlast));
            end else begin
                want = token_fifo.pop_front();
                if (m_tdata[3:0] != want.kind || m_tdata[6:4] != want.err ||
                    m_tdata[22:7] != want.line || m_tdata[23] != 1'b0 ||
                    m_tlast != want.last)
                    note_fault($sformatf({"token %0d: expected kind %0d err %0d line %0d ",
                                          "last %0d, got kind %0d err %0d line %0d last %0d ",
                                          "pad %0d"},
                                         tokens_seen, want.kind, want.err, want.line,
                                         want.last, m_tdata[3:0], m_tdata[6:4],
                                         m_tdata[22:7], m_tlast, m_tdata[23]));
            end
            tokens_seen++;
        end
        if (aresetn && s_tvalid && s_tready) scan_byte(s_tdata, s_tuser);
    end

    // watchdog on cycles where neither side moves a word
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("table_driven_token_scanner regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ---------------------------------------------------------------
    // run sequence
    // ---------------------------------------------------------------
    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 26;
        recv_idle_pct = 55;

        // directed: keyword closed by an operator, constant closed by an operator,
        // lone equal, colon before newline and before an operator, digit then letter
        // with a swallowed letter, top byte as unknown symbol, nul after a word,
        // end mark after a colon, remaining operators, unknown symbol inside a word
        push_text("fin+9-=:\n:)5zq");
        push_byte(8'hFF);
        push_text(",a");
        push_byte(NUL);
        push_byte(":");
        push_end();
        push_text(";(:=b#");
        push_end();
        wait_drained();

        // sender busy less than receiver
        add_random(PHASE_ITEMS);
        wait_drained();

        // roles swapped
        send_idle_pct = 55;
        recv_idle_pct = 26;
        add_random(PHASE_ITEMS);
        wait_drained();

        // full rate, with one long receiver stall while bytes keep coming
        send_idle_pct = 0;
        recv_idle_pct = 0;
        add_random(PHASE_ITEMS);
        stall_req = stall_req + 1;
        wait_drained();

        // a short tail of text at full rate
        add_random(60);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (token_fifo.size() != 0)
            note_fault($sformatf("%0d tokens never arrived", token_fifo.size()));

        if (fault_count == 0) begin
            $display("table_driven_token_scanner regression: pass");
        end else begin
            $display("table_driven_token_scanner regression: fail");
        end
        $finish;
    end

endmodule
